FILE: rtl/assert_macros.svh
// Assertion macros shared by the loop detector RTL.
// Each macro assumes the enclosing module has clk and active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define NKD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as the antecedent.
`define NKD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define NKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nkd_pkg.sv
// Types and constants for the nearest key frame loop detector.
// Used by the configuration, controller, datapath and top-level files.
`timescale 1ns / 1ps

package nkd_pkg;

    localparam int RETRY_STEP_W = 16;
    localparam int MIN_GAP_W    = 13;
    localparam int AREA_W       = 32;
    localparam int EDGE_W       = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int IDX_OUT_W    = 12;
    localparam int DIST_OUT_W   = 34;
    localparam int SKIP_W       = 32;
    localparam int BEST_W       = 28;
    localparam int TARGET_SHIFT = 9;

    // Starting best distance: one million metres in 1/256 m units.
    localparam logic [BEST_W-1:0] START_MIN_DIST = 28'd256000000;

    localparam logic [RETRY_STEP_W-1:0] RETRY_STEP_RST   = 16'd5;
    localparam logic [MIN_GAP_W-1:0]    MIN_GAP_RST      = 13'd100;
    localparam logic [AREA_W-1:0]       MATCH_RADIUS_RST = 32'd2560;
    localparam logic [EDGE_W-1:0]       EDGE_MARGIN_RST  = 13'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY_STEP   = 2'd0,
        CFG_MIN_GAP      = 2'd1,
        CFG_MATCH_RADIUS = 2'd2,
        CFG_EDGE_MARGIN  = 2'd3
    } nkd_cfg_idx_t;

    typedef struct packed {
        logic [RETRY_STEP_W-1:0] retry_step;
        logic [MIN_GAP_W-1:0]    min_gap_frames;
        logic [AREA_W-1:0]       match_radius;
        logic [EDGE_W-1:0]       edge_margin;
    } nkd_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } nkd_state_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic decide;
    } nkd_cmd_t;

    typedef struct packed {
        logic search_ok;
        logic in_range;
        logic pipe_empty;
    } nkd_status_t;

endpackage

FILE: rtl/nearest_keyframe_loop_detector.sv
// Top level of the nearest key frame loop detector.
// Depends on nkd_pkg, nkd_cfg, nkd_ctrl, nkd_dp and nkd_ram.
//
// Usage: a key frame word (pos_x, pos_y, pos_z) is taken at a rising edge
// where start is high and busy is low. Each word yields exactly one result
// word, shown for a single cycle with done high; the receiver cannot stall.
// Configuration writes use cfg_valid / cfg_ready (ready is always high) with
// cfg_index selecting the retry step, the minimum gap, the match radius or
// the edge margin. The user must make them only while the block is idle; the
// block itself does not enforce this. A word that triggers no search goes
// through check and decide, then done rises from its register. A searching
// word goes through check, a scan of K older frames (K < HISTORY_DEPTH),
// a drain until the distance pipeline is empty, and decide. busy drops the
// cycle that done rises, and the next word is taken at the edge that ends that
// cycle, never before the last result. The single read port of the history
// RAM feeds one stored frame per cycle into a four-stage distance pipeline.
// Reset clears the frame count, the skip counter and target, and the
// configuration to its defaults; the history RAM needs no clearing pass.
`timescale 1ns / 1ps

module nearest_keyframe_loop_detector #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int POS_WIDTH     = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [POS_WIDTH-1:0]        pos_x,
    input  logic signed [POS_WIDTH-1:0]        pos_y,
    input  logic signed [POS_WIDTH-1:0]        pos_z,
    output logic                               done,
    output logic                               loop_found,
    output logic                               searched,
    output logic [nkd_pkg::IDX_OUT_W-1:0]      match_index,
    output logic [nkd_pkg::DIST_OUT_W-1:0]     best_distance,
    output logic                               store_full,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nkd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nkd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nkd_pkg::*;

    nkd_cfg_t    cfg;
    nkd_cmd_t    cmd;
    nkd_status_t status;

    nkd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nkd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    nkd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POS_WIDTH     (POS_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .done          (done),
        .loop_found    (loop_found),
        .searched      (searched),
        .match_index   (match_index),
        .best_distance (best_distance),
        .store_full    (store_full)
    );

endmodule

FILE: rtl/nkd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module nkd_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/nkd_cfg.sv
// Configuration register file of the loop detector.
// Depends on nkd_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps

module nkd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nkd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nkd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output nkd_pkg::nkd_cfg_t               cfg
);
    import nkd_pkg::*;

    nkd_cfg_t cfg_reg;
    nkd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (nkd_cfg_idx_t'(cfg_index))
                CFG_RETRY_STEP:   cfg_next.retry_step     = cfg_data[RETRY_STEP_W-1:0];
                CFG_MIN_GAP:      cfg_next.min_gap_frames = cfg_data[MIN_GAP_W-1:0];
                CFG_MATCH_RADIUS: cfg_next.match_radius   = cfg_data[AREA_W-1:0];
                CFG_EDGE_MARGIN:  cfg_next.edge_margin    = cfg_data[EDGE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_step     <= RETRY_STEP_RST;
            cfg_reg.min_gap_frames <= MIN_GAP_RST;
            cfg_reg.match_radius   <= MATCH_RADIUS_RST;
            cfg_reg.edge_margin    <= EDGE_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

FILE: rtl/nkd_ctrl.sv
// Controller state machine of the loop detector.
// Depends on nkd_pkg for the state, command and status types.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nkd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  nkd_pkg::nkd_status_t status,
    output nkd_pkg::nkd_cmd_t    cmd
);
    import nkd_pkg::*;

    nkd_state_t state_reg;
    nkd_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.search_ok ? ST_SCAN : ST_DECIDE;
            end
            ST_SCAN:
            begin
                if (!status.in_range)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            ST_CHECK:  cmd = '0;
            ST_SCAN:   cmd.issue  = 1'b1;
            ST_DRAIN:  cmd = '0;
            ST_DECIDE: cmd.decide = 1'b1;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `NKD_ASSERT_NEXT(a_accept_to_check, state_reg == ST_IDLE && start, state_reg == ST_CHECK, "accepted word did not move to check")
    `NKD_ASSERT_IMPL(a_decide_after_drain, state_reg == ST_DECIDE, status.pipe_empty, "decision taken with distance pipeline busy")

endmodule

FILE: rtl/nkd_dp.sv
// Datapath of the loop detector: history RAM, frame and skip counters,
// the distance pipeline and the result registers. Depends on nkd_pkg and nkd_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nkd_dp #(
    parameter int HISTORY_DEPTH = 4096,
    parameter int POS_WIDTH     = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nkd_pkg::nkd_cmd_t                   cmd,
    output nkd_pkg::nkd_status_t                status,
    input  nkd_pkg::nkd_cfg_t                   cfg,
    input  logic signed [POS_WIDTH-1:0]         pos_x,
    input  logic signed [POS_WIDTH-1:0]         pos_y,
    input  logic signed [POS_WIDTH-1:0]         pos_z,
    output logic                                done,
    output logic                                loop_found,
    output logic                                searched,
    output logic [nkd_pkg::IDX_OUT_W-1:0]       match_index,
    output logic [nkd_pkg::DIST_OUT_W-1:0]      best_distance,
    output logic                                store_full
);
    import nkd_pkg::*;

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = AW + 1;
    localparam int LIM_W  = ((CW > MIN_GAP_W) ? CW : MIN_GAP_W) + 1;
    localparam int EM_W   = (AW > EDGE_W) ? AW : EDGE_W;
    localparam int IDX_W  = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;
    localparam int RW     = 3 * POS_WIDTH;
    localparam int SUM_W  = POS_WIDTH + 2;
    localparam int DCMP_W = (SUM_W > BEST_W) ? SUM_W : BEST_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

    function automatic logic [POS_WIDTH-1:0] abs_diff(
        input logic [POS_WIDTH-1:0] a,
        input logic [POS_WIDTH-1:0] b
    );
        logic signed [POS_WIDTH:0] d;
        begin
            d = $signed({a[POS_WIDTH-1], a}) - $signed({b[POS_WIDTH-1], b});
            abs_diff = d[POS_WIDTH] ? POS_WIDTH'(-d) : d[POS_WIDTH-1:0];
        end
    endfunction

    // Control registers.
    logic [CW-1:0]     frame_count_reg, frame_count_next;
    logic [SKIP_W-1:0] skip_counter_reg, skip_counter_next;
    logic [SKIP_W-1:0] skip_target_reg, skip_target_next;
    logic              primed_reg, primed_next;
    logic              full_reg, full_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              have_reg, have_next;
    logic              done_reg;

    // Payload registers.
    logic [POS_WIDTH-1:0]  cur_x_reg, cur_y_reg, cur_z_reg;
    logic [AW-1:0]         s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [POS_WIDTH-1:0]  s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic [SUM_W-1:0]      s3_sum_reg;
    logic [BEST_W-1:0]     best_reg;
    logic [AW-1:0]         best_idx_reg;
    logic                  found_out_reg, searched_out_reg, full_out_reg;
    logic [IDX_OUT_W-1:0]  idx_out_reg;
    logic [DIST_OUT_W-1:0] dist_out_reg;

    logic                  found_res, searched_res;
    logic [IDX_OUT_W-1:0]  idx_res;
    logic [DIST_OUT_W-1:0] dist_res;

    logic                  rd_en;
    logic [RW-1:0]         rd_data;
    logic [LIM_W-1:0]      idx_ext, count_ext, gap_ext;
    logic                  in_range;
    logic                  better;
    logic [IDX_W-1:0]      best_idx_ext;
    logic                  near_start;
    logic [SKIP_W-1:0]     far_target;

    nkd_ram #(
        .WIDTH (RW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.accept && !(frame_count_reg == DEPTH_C)),
        .waddr (frame_count_reg[AW-1:0]),
        .wdata ({pos_x, pos_y, pos_z}),
        .re    (rd_en),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    // Candidate i is in range while i + 1 < n and i + min_gap <= n.
    assign idx_ext   = LIM_W'(scan_idx_reg);
    assign count_ext = LIM_W'(frame_count_reg);
    assign gap_ext   = LIM_W'(cfg.min_gap_frames);
    assign in_range  = (idx_ext + 1'b1 < count_ext) && (idx_ext + gap_ext <= count_ext);
    assign rd_en     = cmd.issue && in_range;

    assign status.in_range   = in_range;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign status.search_ok  = !full_reg && (skip_counter_reg >= skip_target_reg) &&
                               (count_ext >= gap_ext + 1'b1);

    assign better       = DCMP_W'(s3_sum_reg) < DCMP_W'(best_reg);
    assign best_idx_ext = IDX_W'(best_idx_reg);
    assign near_start   = EM_W'(best_idx_reg) < EM_W'(cfg.edge_margin);
    assign far_target   = (SKIP_W'(best_reg >> TARGET_SHIFT) < SKIP_W'(cfg.retry_step)) ?
                          SKIP_W'(cfg.retry_step) : SKIP_W'(best_reg >> TARGET_SHIFT);

    always_comb
    begin
        frame_count_next  = frame_count_reg;
        skip_counter_next = skip_counter_reg;
        skip_target_next  = skip_target_reg;
        primed_next       = primed_reg;
        full_next         = full_reg;
        scan_idx_next     = scan_idx_reg;
        have_next         = have_reg;
        found_res         = 1'b0;
        searched_res      = 1'b0;
        idx_res           = '0;
        dist_res          = '0;

        if (cmd.accept)
        begin
            if (!primed_reg)
            begin
                skip_target_next = SKIP_W'(cfg.retry_step);
                primed_next      = 1'b1;
            end
            full_next     = (frame_count_reg == DEPTH_C);
            scan_idx_next = '0;
            have_next     = 1'b0;
            if (frame_count_reg != DEPTH_C)
            begin
                frame_count_next = frame_count_reg + 1'b1;
                if (skip_counter_reg != '1)
                begin
                    skip_counter_next = skip_counter_reg + 1'b1;
                end
            end
        end

        if (rd_en)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        if (s3_valid_reg && better)
        begin
            have_next = 1'b1;
        end

        if (cmd.decide && have_reg && !full_reg)
        begin
            searched_res = 1'b1;
            idx_res      = best_idx_ext[IDX_OUT_W-1:0];
            dist_res     = DIST_OUT_W'(best_reg);
            // A match too close to the start of the history leaves the
            // counter and target alone.
            if (!near_start)
            begin
                skip_counter_next = '0;
                if (AREA_W'(best_reg) > cfg.match_radius)
                begin
                    skip_target_next = far_target;
                end
                else
                begin
                    skip_target_next = SKIP_W'(cfg.retry_step);
                    found_res        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= '0;
            skip_counter_reg <= '0;
            skip_target_reg  <= '0;
            primed_reg       <= 1'b0;
            full_reg         <= 1'b0;
            scan_idx_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            have_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            skip_counter_reg <= skip_counter_next;
            skip_target_reg  <= skip_target_next;
            primed_reg       <= primed_next;
            full_reg         <= full_next;
            scan_idx_reg     <= scan_idx_next;
            s1_valid_reg     <= rd_en;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            have_reg         <= have_next;
            done_reg         <= cmd.decide;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_x_reg <= pos_x;
            cur_y_reg <= pos_y;
            cur_z_reg <= pos_z;
            best_reg  <= START_MIN_DIST;
        end
        else if (s3_valid_reg && better)
        begin
            best_reg     <= BEST_W'(s3_sum_reg);
            best_idx_reg <= s3_idx_reg;
        end
        s1_idx_reg <= scan_idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s2_dx_reg  <= abs_diff(cur_x_reg, rd_data[RW-1:2*POS_WIDTH]);
        s2_dy_reg  <= abs_diff(cur_y_reg, rd_data[2*POS_WIDTH-1:POS_WIDTH]);
        s2_dz_reg  <= abs_diff(cur_z_reg, rd_data[POS_WIDTH-1:0]);
        s3_sum_reg <= SUM_W'(s2_dx_reg) + SUM_W'(s2_dy_reg) + SUM_W'(s2_dz_reg);
        if (cmd.decide)
        begin
            found_out_reg    <= found_res;
            searched_out_reg <= searched_res;
            idx_out_reg      <= idx_res;
            dist_out_reg     <= dist_res;
            full_out_reg     <= full_reg;
        end
    end

    assign done          = done_reg;
    assign loop_found    = found_out_reg;
    assign searched      = searched_out_reg;
    assign match_index   = idx_out_reg;
    assign best_distance = dist_out_reg;
    assign store_full    = full_out_reg;

    `NKD_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held for more than one cycle")
    `NKD_ASSERT_IMPL(a_scan_order, s3_valid_reg && $past(s3_valid_reg), s3_idx_reg == $past(s3_idx_reg) + 1'b1, "history entries compared out of order")
    `NKD_ASSERT(a_count_bound, frame_count_reg <= DEPTH_C, "frame count ran past the history depth")

endmodule
